>>> sv/command_line_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// Command line tokenizer assertion macros
// Shared property wrappers; clk and rst must be in scope where used.
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_MACROS_SVH

// same-cycle implication
`define CLT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("command_line_tokenizer: same-cycle check failed");

// next-cycle implication
`define CLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("command_line_tokenizer: next-cycle check failed");

`endif

>>> sv/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Types, character codes and helpers shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package clt_pkg;

  typedef enum logic [2:0] {
    K_TEXT     = 3'd0,
    K_TEXT_END = 3'd1,
    K_COMMA    = 3'd2,
    K_BANG     = 3'd3,
    K_INT      = 3'd4,
    K_EOL      = 3'd5,
    K_ERROR    = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_WORD  = 3'd1,
    M_QUOTE = 3'd2,
    M_MINUS = 3'd3,
    M_ZERO  = 3'd4,
    M_DEC   = 3'd5,
    M_HEX   = 3'd6,
    M_SKIP  = 3'd7
  } mode_t;

  localparam logic ERR_QUOTE = 1'b0;
  localparam logic ERR_CHAR  = 1'b1;

  localparam int CHAR_W  = 16;
  localparam int VALUE_W = 64;
  localparam int COUNT_W = 11;
  localparam int POS_W   = 10;

  localparam logic [CHAR_W-1:0] CH_NUL   = 16'h0000;
  localparam logic [CHAR_W-1:0] CH_LF    = 16'h000A;
  localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
  localparam logic [CHAR_W-1:0] CH_DQUO  = 16'h0022;
  localparam logic [CHAR_W-1:0] CH_BANG  = 16'h0021;
  localparam logic [CHAR_W-1:0] CH_COMMA = 16'h002C;
  localparam logic [CHAR_W-1:0] CH_MINUS = 16'h002D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_X     = 16'h0078;
  localparam logic [CHAR_W-1:0] CH_UNDER = 16'h005F;

  // result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef struct packed {
    kind_t               kind;
    logic [CHAR_W-1:0]   text_char;
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  token_count;
    logic [POS_W-1:0]    position;
    logic                error_code;
    logic                last;
  } result_t;

  // up to two results from one character
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= 16'h0030) && (c <= 16'h0039);
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return ((c >= 16'h0061) && (c <= 16'h007A)) ||
           ((c >= 16'h0041) && (c <= 16'h005A)) || (c == CH_UNDER);
  endfunction

  function automatic logic is_hex_letter(input logic [CHAR_W-1:0] c);
    return ((c >= 16'h0061) && (c <= 16'h0066)) ||
           ((c >= 16'h0041) && (c <= 16'h0046));
  endfunction

  function automatic logic is_line_end(input logic [CHAR_W-1:0] c);
    return (c == CH_NUL) || (c == CH_LF) || (c == CH_CR);
  endfunction

  // digit or hex letter value; letters have low nibble 1..6
  function automatic logic [3:0] hex_val(input logic [CHAR_W-1:0] c);
    return is_digit(c) ? c[3:0] : 4'(c[3:0] + 4'd9);
  endfunction

  function automatic result_t mk_result(input kind_t kind,
                                        input logic [CHAR_W-1:0] text,
                                        input logic [VALUE_W-1:0] value,
                                        input logic [COUNT_W-1:0] count,
                                        input logic [POS_W-1:0] pos,
                                        input logic code);
    result_t r;
    r.kind        = kind;
    r.text_char   = text;
    r.value       = value;
    r.token_count = count;
    r.position    = pos;
    r.error_code  = code;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

>>> sv/clt_scan.sv
// ----------------------------------------------------------------------------
// clt_scan
// Input register plus the scanner state machine; one character per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module clt_scan #(
  parameter int LINE_CHARS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [clt_pkg::CHAR_W-1:0]    ch,
  input  logic                          room,
  output clt_pkg::push_t                push
);
  import clt_pkg::*;

  localparam int IDX_W = $clog2(LINE_CHARS);
  localparam int TW    = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;
  localparam int PW    = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(LINE_CHARS - 1);

  // input register
  logic              full;
  logic [CHAR_W-1:0] c;
  logic              advance;

  // scanner state
  mode_t              mode, mode_next;
  logic [VALUE_W-1:0] acc, acc_next;
  logic               neg, neg_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [IDX_W-1:0]   tokens, tokens_next;

  // helpers
  logic [IDX_W-1:0]   tok_inc;
  logic [IDX_W:0]     tok_plus;
  logic [TW-1:0]      tok_wide;
  logic [PW-1:0]      idx_wide;
  logic [COUNT_W-1:0] eol_count;
  logic [POS_W-1:0]   pos_now;
  logic [VALUE_W-1:0] int_val;
  logic [VALUE_W-1:0] acc_dec;
  logic [VALUE_W-1:0] acc_hex;

  // token start decode
  result_t            st_res;
  logic               st_emit;
  mode_t              st_mode;
  logic [VALUE_W-1:0] st_acc;
  logic [IDX_W-1:0]   st_tok;
  logic               st_end;

  result_t r0;
  logic    r0_v;
  logic    use_st;
  logic    ended;
  push_t   push_c;

  assign advance  = full && room;
  assign in_stall = full && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      c <= ch;
    end
  end

  assign tok_inc   = (tokens < IDX_MAX) ? IDX_W'(tokens + 1'b1) : tokens;
  assign tok_plus  = {1'b0, tokens} + 1'b1;
  assign tok_wide  = TW'(tok_plus);
  assign eol_count = tok_wide[COUNT_W-1:0];
  assign idx_wide  = PW'(idx);
  assign pos_now   = idx_wide[POS_W-1:0];
  assign int_val   = neg ? (VALUE_W'(0) - acc) : acc;
  assign acc_dec   = (acc << 3) + (acc << 1) + VALUE_W'(c[3:0]);
  assign acc_hex   = (acc << 4) | VALUE_W'(hex_val(c));

  // start of a new token; accumulator and sign are set afresh here, whatever they held
  always_comb begin
    st_emit = 1'b0;
    st_res  = '0;
    st_mode = M_IDLE;
    st_acc  = '0;
    st_tok  = tokens;
    st_end  = 1'b0;
    priority if (is_line_end(c)) begin
      st_emit = 1'b1;
      st_res  = mk_result(K_EOL, '0, '0, eol_count, '0, 1'b0);
      st_end  = 1'b1;
    end else if (c == CH_SPACE) begin
      st_mode = M_IDLE;
    end else if (c == CH_DQUO) begin
      st_tok  = tok_inc;
      st_mode = M_QUOTE;
    end else if (c == CH_COMMA) begin
      st_tok  = tok_inc;
      st_emit = 1'b1;
      st_res  = mk_result(K_COMMA, '0, '0, '0, '0, 1'b0);
    end else if (c == CH_BANG) begin
      st_tok  = tok_inc;
      st_emit = 1'b1;
      st_res  = mk_result(K_BANG, '0, '0, '0, '0, 1'b0);
    end else if (is_digit(c)) begin
      st_tok  = tok_inc;
      st_acc  = VALUE_W'(c[3:0]);
      st_mode = (c == CH_ZERO) ? M_ZERO : M_DEC;
    end else if (c == CH_MINUS) begin
      // remember where the minus stood for a possible error
      st_acc  = VALUE_W'(idx);
      st_mode = M_MINUS;
    end else if (is_alpha(c)) begin
      st_tok  = tok_inc;
      st_emit = 1'b1;
      st_res  = mk_result(K_TEXT, c, '0, '0, '0, 1'b0);
      st_mode = M_WORD;
    end else begin
      st_emit = 1'b1;
      st_res  = mk_result(K_ERROR, '0, '0, '0, pos_now, ERR_CHAR);
      st_mode = M_SKIP;
    end
  end

  always_comb begin
    r0          = '0;
    r0_v        = 1'b0;
    use_st      = 1'b0;
    ended       = 1'b0;
    mode_next   = mode;
    acc_next    = acc;
    neg_next    = neg;
    tokens_next = tokens;
    idx_next    = idx;
    unique case (mode)
      M_IDLE: begin
        use_st = 1'b1;
      end
      M_WORD: begin
        if (is_alpha(c) || is_digit(c)) begin
          r0_v = 1'b1;
          r0   = mk_result(K_TEXT, c, '0, '0, '0, 1'b0);
        end else begin
          r0_v   = 1'b1;
          r0     = mk_result(K_TEXT_END, '0, '0, '0, '0, 1'b0);
          use_st = 1'b1;
        end
      end
      M_QUOTE: begin
        r0_v = 1'b1;
        if (c == CH_DQUO) begin
          r0        = mk_result(K_TEXT_END, '0, '0, '0, '0, 1'b0);
          mode_next = M_IDLE;
        end else if (is_line_end(c)) begin
          r0    = mk_result(K_ERROR, '0, '0, '0, pos_now, ERR_QUOTE);
          ended = 1'b1;
        end else begin
          r0 = mk_result(K_TEXT, c, '0, '0, '0, 1'b0);
        end
      end
      M_MINUS: begin
        if (is_digit(c)) begin
          neg_next    = 1'b1;
          tokens_next = tok_inc;
          acc_next    = VALUE_W'(c[3:0]);
          mode_next   = (c == CH_ZERO) ? M_ZERO : M_DEC;
        end else begin
          r0_v      = 1'b1;
          r0        = mk_result(K_ERROR, '0, '0, '0, acc[POS_W-1:0], ERR_CHAR);
          acc_next  = '0;
          mode_next = M_SKIP;
          ended     = is_line_end(c);
        end
      end
      M_ZERO: begin
        if (c == CH_X) begin
          mode_next = M_HEX;
        end else if (is_digit(c)) begin
          acc_next  = VALUE_W'(c[3:0]);
          mode_next = M_DEC;
        end else begin
          r0_v   = 1'b1;
          r0     = mk_result(K_INT, '0, int_val, '0, '0, 1'b0);
          use_st = 1'b1;
        end
      end
      M_DEC: begin
        if (is_digit(c)) begin
          acc_next = acc_dec;
        end else begin
          r0_v   = 1'b1;
          r0     = mk_result(K_INT, '0, int_val, '0, '0, 1'b0);
          use_st = 1'b1;
        end
      end
      M_HEX: begin
        if (is_digit(c) || is_hex_letter(c)) begin
          acc_next = acc_hex;
        end else begin
          r0_v   = 1'b1;
          r0     = mk_result(K_INT, '0, int_val, '0, '0, 1'b0);
          use_st = 1'b1;
        end
      end
      M_SKIP: begin
        ended = is_line_end(c);
      end
    endcase

    if (use_st) begin
      mode_next   = st_mode;
      acc_next    = st_acc;
      neg_next    = 1'b0;
      tokens_next = st_tok;
      ended       = st_end;
    end

    if (ended) begin
      mode_next   = M_IDLE;
      acc_next    = '0;
      neg_next    = 1'b0;
      tokens_next = '0;
      idx_next    = '0;
    end else if (idx < IDX_MAX) begin
      idx_next = IDX_W'(idx + 1'b1);
    end

    // pack results in order, flag the final one
    push_c = '0;
    if (r0_v) begin
      push_c.r0 = r0;
      push_c.r1 = st_res;
      push_c.n  = (use_st && st_emit) ? 2'd2 : 2'd1;
    end else begin
      push_c.r0 = st_res;
      push_c.n  = (use_st && st_emit) ? 2'd1 : 2'd0;
    end
    if (push_c.n == 2'd2) begin
      push_c.r1.last = 1'b1;
    end else begin
      push_c.r0.last = 1'b1;
    end
    if (!advance) begin
      push_c.n = 2'd0;
    end
    push = push_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      acc    <= '0;
      neg    <= 1'b0;
      idx    <= '0;
      tokens <= '0;
    end else if (advance) begin
      mode   <= mode_next;
      acc    <= acc_next;
      neg    <= neg_next;
      idx    <= idx_next;
      tokens <= tokens_next;
    end
  end

endmodule

>>> sv/clt_queue.sv
// ----------------------------------------------------------------------------
// clt_queue
// Four-entry result queue: takes up to two results a cycle, gives one while the receiver does not stall.
// ----------------------------------------------------------------------------
module clt_queue (
  input  logic             clk,
  input  logic             rst,
  input  clt_pkg::push_t   push,
  output logic             room,
  output logic             head_valid,
  input  logic             pop,
  output clt_pkg::result_t head
);
  import clt_pkg::*;

  result_t         entries [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   cnt;

  // room for a full pair of results
  assign room       = cnt <= (Q_AW + 1)'(Q_DEPTH - 2);
  assign head_valid = cnt != '0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      entries[Q_AW'(wr_ptr + 1'b1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= Q_AW'(wr_ptr + push.n);
      rd_ptr <= Q_AW'(rd_ptr + pop);
      cnt    <= (Q_AW + 1)'(cnt + push.n - pop);
    end
  end

endmodule

>>> sv/command_line_tokenizer.sv
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Console line tokenizer: 16-bit characters in, token results out.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one character (ch) per request.
// Output channel: out_valid / out_stall carry one result per request; last
// marks the final result caused by a character (a character gives 0 to 2).
// An accepted character waits in the input register until the queue has
// room; it is then scanned, and its results are written into the queue,
// whose head drives the output. Throughput is one character per cycle
// while the queue has room. Characters that end a word or a number and
// also emit a token of their own give two results, and the single-result
// output port then sets the pace.
// Results go through a four-entry queue; in_stall rises when the input
// register is full and the queue holds more than two results, so a stalled
// receiver backs up into the input side without dropping anything.
// Reset (rst, synchronous) empties the queue and puts the scanner between
// tokens at character index zero with no tokens counted.
// ----------------------------------------------------------------------------
module command_line_tokenizer #(
  parameter int LINE_CHARS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [clt_pkg::CHAR_W-1:0]         ch,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         kind,
  output logic [clt_pkg::CHAR_W-1:0]         text_char,
  output logic signed [clt_pkg::VALUE_W-1:0] value,
  output logic [clt_pkg::COUNT_W-1:0]        token_count,
  output logic [clt_pkg::POS_W-1:0]          position,
  output logic                               error_code,
  output logic                               last
);
  import clt_pkg::*;

  push_t   push;
  logic    room;
  result_t head;

  clt_scan #(
    .LINE_CHARS(LINE_CHARS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ch       (ch),
    .room     (room),
    .push     (push)
  );

  clt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .head_valid (out_valid),
    .pop        (out_valid && !out_stall),
    .head       (head)
  );

  assign kind        = head.kind;
  assign text_char   = head.text_char;
  assign value       = head.value;
  assign token_count = head.token_count;
  assign position    = head.position;
  assign error_code  = head.error_code;
  assign last        = head.last;

endmodule

>>> sv/clt_checker.sv
// ----------------------------------------------------------------------------
// clt_checker
// Port-level checks on the tokenizer result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "command_line_tokenizer_macros.svh"

module clt_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [2:0]                         kind,
  input logic [clt_pkg::CHAR_W-1:0]         text_char,
  input logic signed [clt_pkg::VALUE_W-1:0] value,
  input logic                               last
);
  import clt_pkg::*;

  // a held result stays put
  `CLT_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(kind) && $stable(text_char) && $stable(value))

  // line end and error always close the results of their character
  `CLT_ASSERT_SAME(a_close_last, out_valid && (kind == K_EOL || kind == K_ERROR), last)

  // unused fields read as zero
  `CLT_ASSERT_SAME(a_text_zero, out_valid && kind != K_TEXT, text_char == '0)
  `CLT_ASSERT_SAME(a_value_zero, out_valid && kind != K_INT, value == '0)

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (.*);

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// command_line_tokenizer testbench
// Feeds console lines one character per request: a few fixed lines, then
// random lines of words, strings, numbers and punctuation, broken lines and
// noise, plus an overlong line. A tracker predicts every token result and
// checks each result in order as it leaves the block, under three
// sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module testbench;
  import clt_pkg::*;

  localparam logic [15:0] LC_A    = 16'h0061;
  localparam logic [15:0] LC_F    = 16'h0066;
  localparam logic [15:0] LC_Z    = 16'h007A;
  localparam logic [15:0] UC_A    = 16'h0041;
  localparam logic [15:0] UC_F    = 16'h0046;
  localparam logic [15:0] UC_Z    = 16'h005A;
  localparam logic [15:0] CH_NINE = 16'h0039;

  localparam logic [9:0]  IDX_MAX = 10'd1023;
  localparam logic [10:0] TOK_MAX = 11'd1023;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [15:0]         ch;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [2:0]          kind;
  logic [15:0]         text_char;
  logic signed [63:0]  value;
  logic [10:0]         token_count;
  logic [9:0]          position;
  logic                error_code;
  logic                last;

  command_line_tokenizer dut (.*);

  function automatic bit decimal_digit(logic [15:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit word_letter(logic [15:0] c);
    return (c >= LC_A && c <= LC_Z) || (c >= UC_A && c <= UC_Z) || c == CH_UNDER;
  endfunction

  function automatic bit line_end(logic [15:0] c);
    return c == CH_NUL || c == CH_LF || c == CH_CR;
  endfunction

  // Predicts the token results of each accepted character and checks the
  // results leaving the block against them, oldest first.
  class token_tracker;
    result_t     tokens_due[$];
    result_t     step_out[$];
    mode_t       mode = M_IDLE;
    logic [63:0] acc = '0;
    logic        neg = 1'b0;
    logic [9:0]  idx = '0;
    logic [10:0] ntok = '0;
    int          mismatches = 0;

    function void add(kind_t k, logic [15:0] t, logic [63:0] v, logic [10:0] n,
                      logic [9:0] p, logic e);
      result_t r;
      r.kind        = k;
      r.text_char   = t;
      r.value       = v;
      r.token_count = n;
      r.position    = p;
      r.error_code  = e;
      r.last        = 1'b0;
      step_out.push_back(r);
    endfunction

    function void count_tok();
      if (ntok < TOK_MAX) ntok++;
    endfunction

    function void clear_line();
      mode = M_IDLE;
      acc  = '0;
      neg  = 1'b0;
      idx  = '0;
      ntok = '0;
    endfunction

    function void first_digit(logic [15:0] c);
      count_tok();
      acc  = 64'(c - CH_ZERO);
      mode = (c == CH_ZERO) ? M_ZERO : M_DEC;
    endfunction

    function void flush_number();
      add(K_INT, '0, neg ? 64'd0 - acc : acc, '0, '0, 1'b0);
      acc  = '0;
      neg  = 1'b0;
      mode = M_IDLE;
    endfunction

    // character seen between tokens; returns 1 when the line is over
    function bit open_token(logic [15:0] c);
      mode = M_IDLE;
      if (line_end(c)) begin
        add(K_EOL, '0, '0, ntok + 11'd1, '0, 1'b0);
        return 1'b1;
      end
      if (c == CH_SPACE) return 1'b0;
      if (c == CH_DQUO) begin
        count_tok();
        mode = M_QUOTE;
      end else if (c == CH_COMMA) begin
        count_tok();
        add(K_COMMA, '0, '0, '0, '0, 1'b0);
      end else if (c == CH_BANG) begin
        count_tok();
        add(K_BANG, '0, '0, '0, '0, 1'b0);
      end else if (decimal_digit(c)) begin
        neg = 1'b0;
        first_digit(c);
      end else if (c == CH_MINUS) begin
        // remember where the minus stood in case no digit follows
        acc  = 64'(idx);
        mode = M_MINUS;
      end else if (word_letter(c)) begin
        count_tok();
        add(K_TEXT, c, '0, '0, '0, 1'b0);
        mode = M_WORD;
      end else begin
        add(K_ERROR, '0, '0, '0, idx, ERR_CHAR);
        mode = M_SKIP;
      end
      return 1'b0;
    endfunction

    function void take_char(logic [15:0] c);
      bit      ended = 1'b0;
      result_t r;
      step_out.delete();
      case (mode)
        M_WORD: begin
          if (word_letter(c) || decimal_digit(c)) begin
            add(K_TEXT, c, '0, '0, '0, 1'b0);
          end else begin
            add(K_TEXT_END, '0, '0, '0, '0, 1'b0);
            ended = open_token(c);
          end
        end
        M_QUOTE: begin
          if (c == CH_DQUO) begin
            add(K_TEXT_END, '0, '0, '0, '0, 1'b0);
            mode = M_IDLE;
          end else if (line_end(c)) begin
            add(K_ERROR, '0, '0, '0, idx, ERR_QUOTE);
            ended = 1'b1;
          end else begin
            add(K_TEXT, c, '0, '0, '0, 1'b0);
          end
        end
        M_MINUS: begin
          if (decimal_digit(c)) begin
            neg = 1'b1;
            first_digit(c);
          end else begin
            add(K_ERROR, '0, '0, '0, acc[9:0], ERR_CHAR);
            acc   = '0;
            mode  = M_SKIP;
            ended = line_end(c);
          end
        end
        M_ZERO: begin
          if (c == CH_X) begin
            mode = M_HEX;
          end else if (decimal_digit(c)) begin
            acc  = 64'(c - CH_ZERO);
            mode = M_DEC;
          end else begin
            flush_number();
            ended = open_token(c);
          end
        end
        M_DEC: begin
          if (decimal_digit(c)) begin
            acc = acc * 64'd10 + 64'(c - CH_ZERO);
          end else begin
            flush_number();
            ended = open_token(c);
          end
        end
        M_HEX: begin
          if (decimal_digit(c)) begin
            acc = {acc[59:0], 4'(c - CH_ZERO)};
          end else if (c >= LC_A && c <= LC_F) begin
            acc = {acc[59:0], 4'(c - LC_A + 16'd10)};
          end else if (c >= UC_A && c <= UC_F) begin
            acc = {acc[59:0], 4'(c - UC_A + 16'd10)};
          end else begin
            flush_number();
            ended = open_token(c);
          end
        end
        M_SKIP: ended = line_end(c);
        default: ended = open_token(c);
      endcase
      if (ended) clear_line();
      else if (idx < IDX_MAX) idx++;
      if (step_out.size() > 0) begin
        r = step_out.pop_back();
        r.last = 1'b1;
        step_out.push_back(r);
      end
      foreach (step_out[i]) tokens_due.push_back(step_out[i]);
    endfunction

    function void match_token(result_t got);
      result_t want;
      if (tokens_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result kind %0d char %h value %h count %0d pos %0d code %0d",
                   $realtime, got.kind, got.text_char, got.value, got.token_count,
                   got.position, got.error_code);
        return;
      end
      want = tokens_due.pop_front();
      if (got.kind !== want.kind || got.text_char !== want.text_char ||
          got.value !== want.value || got.token_count !== want.token_count ||
          got.position !== want.position || got.error_code !== want.error_code ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected kind %0d char %h value %h count %0d pos %0d code %0d last %0d",
                   want.kind, want.text_char, want.value, want.token_count,
                   want.position, want.error_code, want.last);
          $display("  actual   kind %0d char %h value %h count %0d pos %0d code %0d last %0d",
                   got.kind, got.text_char, got.value, got.token_count,
                   got.position, got.error_code, got.last);
        end
      end
    endfunction
  endclass

  token_tracker tracker;
  result_t      seen;
  int           send_idle_pct;
  int           stall_pct;
  int           chars_sent;
  int           quiet_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen.kind        = kind_t'(kind);
      seen.text_char   = text_char;
      seen.value       = value;
      seen.token_count = token_count;
      seen.position    = position;
      seen.error_code  = error_code;
      seen.last        = last;
      tracker.match_token(seen);
    end
  end

  // no request moving on either side for too long means the block hung
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_char(input logic [15:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_char(c);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char({8'h00, s[i]});
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tracker.tokens_due.size() != 0) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_letter();
    case ($urandom_range(2))
      0: return 16'(LC_A + $urandom_range(25));
      1: return 16'(UC_A + $urandom_range(25));
      default: return CH_UNDER;
    endcase
  endfunction

  function automatic logic [15:0] pick_digit();
    return 16'(CH_ZERO + $urandom_range(9));
  endfunction

  function automatic logic [15:0] pick_hex();
    case ($urandom_range(2))
      0: return pick_digit();
      1: return 16'(LC_A + $urandom_range(5));
      default: return 16'(UC_A + $urandom_range(5));
    endcase
  endfunction

  function automatic logic [15:0] pick_line_end();
    case ($urandom_range(2))
      0: return CH_NUL;
      1: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  // anything a quoted string passes through, now and then a full 16-bit code
  function automatic logic [15:0] string_char();
    logic [15:0] c;
    do begin
      if ($urandom_range(4) == 0) c = 16'($urandom);
      else c = 16'($urandom_range(16'h20, 16'h7E));
    end while (c == CH_DQUO || line_end(c));
    return c;
  endfunction

  function automatic string edge_number();
    case ($urandom_range(6))
      0: return "18446744073709551615";
      1: return "-9223372036854775808";
      2: return "9223372036854775807";
      3: return "0xFFFFFFFFFFFFFFFF";
      4: return "-0x8000000000000000";
      5: return "0x1ffffffffffffffff";
      default: return "00x5";
    endcase
  endfunction

  task automatic send_token();
    int n;
    case ($urandom_range(6))
      0: begin
        send_char(pick_letter());
        repeat ($urandom_range(6)) send_char($urandom_range(2) ? pick_letter() : pick_digit());
      end
      1: begin
        send_char(CH_DQUO);
        repeat ($urandom_range(6)) send_char(string_char());
        send_char(CH_DQUO);
      end
      2: send_char(CH_COMMA);
      3: send_char(CH_BANG);
      4: begin
        if ($urandom_range(2) == 0) send_char(CH_MINUS);
        n = ($urandom_range(7) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 6);
        repeat (n) send_char(pick_digit());
      end
      5: begin
        if ($urandom_range(2) == 0) send_char(CH_MINUS);
        send_char(CH_ZERO);
        send_char(CH_X);
        n = ($urandom_range(7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 6);
        repeat (n) send_char(pick_hex());
      end
      default: send_text(edge_number());
    endcase
    repeat ($urandom_range(2)) send_char(CH_SPACE);
  endtask

  task automatic send_random_line();
    int flavor;
    flavor = $urandom_range(99);
    if (flavor < 5) begin
      repeat ($urandom_range(1, 8)) send_char(16'($urandom));
    end else begin
      repeat ($urandom_range(7)) send_token();
      if (flavor < 20) begin
        case ($urandom_range(2))
          0: send_char(16'($urandom));
          1: begin
            // minus followed by a space, a letter or the next token, which may start with a digit
            send_char(CH_MINUS);
            case ($urandom_range(2))
              0: send_char(CH_SPACE);
              1: send_char(pick_letter());
              default: ;
            endcase
          end
          default: begin
            // string left open up to the line end, unless a later token's quote closes it
            send_char(CH_DQUO);
            repeat ($urandom_range(3)) send_char(string_char());
          end
        endcase
        repeat ($urandom_range(2)) send_token();
      end
    end
    send_char(pick_line_end());
  endtask

  task automatic run_phase(input int idle_pct, input int stall, input int target);
    int first;
    first         = chars_sent;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    while (chars_sent - first < target) begin
      send_random_line();
      if ($urandom_range(49) == 0) drain();
    end
    drain();
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    ch            = '0;
    send_idle_pct = 25;
    stall_pct     = 54;
    chars_sent    = 0;
    quiet_cycles  = 0;
    tracker       = new;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // word ended by a comma, quoted string, exclamation
    send_text("ab,\"q\"!");
    send_char(CH_LF);
    // signed hex, decimal, line ended by CR right after a number
    send_text("-0x1F,9");
    send_char(CH_CR);
    // "0x" with no digits
    send_text("0x");
    send_char(CH_NUL);
    // open string at line end
    send_text("\"x");
    send_char(CH_LF);
    // lone minus
    send_text("-a");
    send_char(CH_LF);
    send_char(16'hFFFF);
    send_char(CH_LF);

    run_phase(25, 54, 180);

    run_phase(54, 25, 180);
    // token count saturates on an overlong line
    repeat (1030) send_char(CH_COMMA);
    send_char(CH_LF);
    drain();

    run_phase(0, 0, 180);

    drain();
    repeat (20) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.tokens_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
